// ===== sv/slmf_pkg.sv =====
// shared types and constants for the suffix maximum leader filter
package slmf_pkg;

   localparam int MAX_ELEMENTS_DEFAULT = 64;
   localparam int VALUE_WIDTH          = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_LOAD,
      ST_EMIT_RD,
      ST_EMIT_LOAD
   } state_type;

   typedef struct packed {
      logic latch_in;
      logic pop;
      logic load_top;
      logic push;
      logic emit_rd;
      logic emit_load;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic top_less;
      logic is_final;
      logic emit_last;
      logic out_free;
   } stat_type;

endpackage

// ===== sv/slmf_ctrl.sv =====
// controller state machine for the suffix maximum leader filter
module slmf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output slmf_pkg::cmd_type cmd,
   input  slmf_pkg::stat_type stat
);
   import slmf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch_in = 1'b1;
               state_in     = ST_CMP;
            end
         end
         ST_CMP: begin
            if (stat.top_less) begin
               cmd.pop  = 1'b1;
               state_in = ST_LOAD;
            end else begin
               cmd.push = 1'b1;
               state_in = stat.is_final ? ST_EMIT_RD : ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.load_top = 1'b1;
            state_in     = ST_CMP;
         end
         ST_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            if (stat.out_free) begin
               cmd.emit_load = 1'b1;
               if (stat.emit_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  state_in  = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/slmf_dpath.sv =====
// survivor stack memory, counters and output register
module slmf_dpath #(
   parameter int MAX_ELEMENTS = slmf_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [slmf_pkg::VALUE_WIDTH-1:0]    in_value,
   input  logic                                in_final,
   input  slmf_pkg::cmd_type                   cmd,
   output slmf_pkg::stat_type                  stat,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [slmf_pkg::VALUE_WIDTH-1:0]    out_value,
   output logic                                out_last,
   output logic                                out_ovf
);
   import slmf_pkg::*;

   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int AW = $clog2(MAX_ELEMENTS);

   logic [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];

   logic [VALUE_WIDTH-1:0] val_ff, top_ff, rd_ff, out_value_ff;
   logic                   fin_ff, out_last_ff, out_ovf_ff;
   logic [CW-1:0]          count_ff, count_in;
   logic                   ovf_ff, ovf_in, out_valid_ff, out_valid_in;
   logic [AW-1:0]          idx_ff, idx_in;

   logic [CW-1:0] below_top;
   logic [AW-1:0] rd_addr;
   logic          rd_en, full, wr_en;

   assign full      = (count_ff == CW'(MAX_ELEMENTS));
   assign wr_en     = cmd.push && !full;
   assign below_top = count_ff - CW'(2);
   assign rd_en     = cmd.pop || cmd.emit_rd;
   assign rd_addr   = cmd.pop ? below_top[AW-1:0] : idx_ff;

   assign stat.top_less  = (count_ff != '0) && ($signed(top_ff) < $signed(val_ff));
   assign stat.is_final  = fin_ff;
   assign stat.emit_last = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign stat.out_free  = !out_valid_ff || out_ready;

   // stack storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= val_ff;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         val_ff <= in_value;
         fin_ff <= in_final;
      end
      if (wr_en) begin
         top_ff <= val_ff;
      end else if (cmd.load_top) begin
         top_ff <= rd_ff;
      end
      if (cmd.emit_load) begin
         out_value_ff <= rd_ff;
         out_last_ff  <= stat.emit_last;
         out_ovf_ff   <= ovf_ff;
      end
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
      if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.push && full) begin
         ovf_in = 1'b1;
      end
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit_load) begin
         out_valid_in = 1'b1;
         idx_in       = idx_ff + AW'(1);
      end
      if (cmd.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;
   assign out_ovf   = out_ovf_ff;

endmodule

// ===== sv/suffix_maximum_leader_filter.sv =====
// top level of the suffix maximum leader filter
//
//   channel  direction  tdata             tlast       tuser
//   req_     in         [31:0] value      is_final    -
//   rsp_     out        [31:0] kept_value end_of_run  [0] overflowed
//
// an input beat is accepted in idle; each stack entry it removes takes a compare
// state that pops through the stack memory read port and a load state for the new top,
// then it is pushed; a final beat emits each survivor through the same read port
// reset is synchronous and clears the stack count, overflow flag, emit index and output valid flag
// a stalled output beat holds the emit loop; a new input beat is taken while the
// last beat of a run still waits
module suffix_maximum_leader_filter #(
   parameter int MAX_ELEMENTS = slmf_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] kept_value
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser    // [0] overflowed
);
   import slmf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   slmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   slmf_dpath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .in_value  (req_tdata),
      .in_final  (req_tlast),
      .cmd       (cmd),
      .stat      (stat),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_ovf   (rsp_tuser[0])
   );

endmodule

// ===== sv/slmf_checker.sv =====
// port level checks for the suffix maximum leader filter
module slmf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [0:0]  rsp_tuser
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while previous item in work");

   // reset leaves the block idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   // a result right after reset needs an accepted input beat
   a_no_result_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result without a final input beat");

endmodule

bind suffix_maximum_leader_filter slmf_checker u_slmf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the suffix maximum leader filter
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import slmf_pkg::*;

   localparam int STACK_DEPTH = MAX_ELEMENTS_DEFAULT;
   localparam logic signed [VALUE_WIDTH-1:0] MOST_NEG = 32'h8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] MOST_POS = 32'h7fff_ffff;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_NARROW,
      SPREAD_FALLING,
      SPREAD_STRICT_FALL
   } spread_type;

   typedef struct {
      logic signed [VALUE_WIDTH-1:0] kept_value;
      logic                          end_of_run;
      logic                          overflowed;
   } leader_beat_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] value
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] kept_value
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;        // [0] overflowed

   // predictor state
   logic signed [VALUE_WIDTH-1:0] survivor [STACK_DEPTH];
   int                            stack_fill = 0;
   logic                          dropped    = 1'b0;
   leader_beat_type               expected_leaders [$];

   bit idle_on        = 1'b1;
   int receiver_hold  = 0;
   int failures       = 0;
   int items_sent     = 0;
   int runs_sent      = 0;
   int results_seen   = 0;
   int overflow_runs  = 0;

   suffix_maximum_leader_filter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[suffix_maximum_leader_filter] ERROR");
      $finish;
   end

   // monotonic stack: pop strictly smaller entries, push unless full
   task automatic predict_leaders(input logic signed [VALUE_WIDTH-1:0] value,
                                  input logic is_final);
      leader_beat_type beat;
      while (stack_fill > 0 && survivor[stack_fill-1] < value)
         stack_fill--;
      if (stack_fill < STACK_DEPTH) begin
         survivor[stack_fill] = value;
         stack_fill++;
      end else begin
         dropped = 1'b1;
      end
      if (is_final) begin
         for (int i = 0; i < stack_fill; i++) begin
            beat.kept_value = survivor[i];
            beat.end_of_run = (i == stack_fill - 1);
            beat.overflowed = dropped;
            expected_leaders.push_back(beat);
         end
         if (dropped)
            overflow_runs++;
         stack_fill = 0;
         dropped    = 1'b0;
      end
   endtask

   task automatic send_element(input logic signed [VALUE_WIDTH-1:0] value,
                               input logic is_final);
      int gap;
      gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_final;
      do @(posedge clock); while (!req_tready);
      predict_leaders(value, is_final);
      items_sent++;
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (expected_leaders.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_random_run(input int length, input spread_type spread);
      logic signed [VALUE_WIDTH-1:0] value;
      value = $urandom_range(32'h4000_0000, 32'h7fff_0000);
      for (int i = 0; i < length; i++) begin
         case (spread)
            SPREAD_FULL: begin
               value = $urandom;
            end
            SPREAD_NARROW: begin
               value = $signed($urandom_range(0, 8)) - 4;
            end
            SPREAD_FALLING: begin
               if ($urandom_range(0, 7) == 0)
                  value = $urandom;
               else
                  value = value - $urandom_range(0, 1000);
            end
            default: begin
               value = value - $urandom_range(1, 1000);
            end
         endcase
         send_element(value, i == length - 1);
      end
      runs_sent++;
   endtask

   task automatic test_single_element();
      send_element(MOST_NEG, 1'b1);
      send_element(MOST_POS, 1'b1);
      runs_sent += 2;
   endtask

   task automatic test_extremes();
      send_element(MOST_POS, 1'b0);
      send_element(MOST_NEG, 1'b0);
      send_element(32'sd0, 1'b0);
      send_element(-32'sd1, 1'b0);
      send_element(MOST_NEG, 1'b1);
      runs_sent++;
   endtask

   task automatic test_equal_values();
      repeat (3) send_element(32'sd5, 1'b0);
      send_element(32'sd5, 1'b1);
      runs_sent++;
   endtask

   task automatic test_rising_run();
      for (int i = -3; i <= 1; i++)
         send_element(i, i == 1);
      runs_sent++;
   endtask

   task automatic test_falling_run();
      for (int i = 2; i >= -2; i--)
         send_element(i, i == -2);
      runs_sent++;
   endtask

   // exactly full, overflow with smallest final, overflow then full clear-out
   task automatic test_full_store();
      send_random_run(STACK_DEPTH, SPREAD_STRICT_FALL);
      send_random_run(STACK_DEPTH + 4, SPREAD_STRICT_FALL);
      for (int i = 0; i < STACK_DEPTH + 2; i++)
         send_element(32'sd100_000 - i, 1'b0);
      send_element(MOST_POS, 1'b1);
      runs_sent++;
   endtask

   task automatic test_receiver_hold();
      receiver_hold = 300;
      send_random_run(24, SPREAD_STRICT_FALL);
      send_random_run(6, SPREAD_FALLING);
      send_random_run(4, SPREAD_NARROW);
   endtask

   task automatic test_random_runs(input int item_target);
      int stop_at;
      stop_at = items_sent + item_target;
      while (items_sent < stop_at)
         send_random_run($urandom_range(1, 24), spread_type'($urandom_range(0, 2)));
   endtask

   // receiver: ready pacing and result check
   initial begin
      int gap_left;
      int hold_left;
      leader_beat_type want;
      gap_left  = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_leaders.size() == 0) begin
               $error("unexpected beat: kept_value %0d", $signed(rsp_tdata));
               failures++;
            end else begin
               want = expected_leaders.pop_front();
               if ($signed(rsp_tdata) !== want.kept_value) begin
                  $error("kept_value expected %0d actual %0d", want.kept_value,
                         $signed(rsp_tdata));
                  failures++;
               end
               if (rsp_tlast !== want.end_of_run) begin
                  $error("end_of_run expected %0b actual %0b", want.end_of_run, rsp_tlast);
                  failures++;
               end
               if (rsp_tuser[0] !== want.overflowed) begin
                  $error("overflowed expected %0b actual %0b", want.overflowed, rsp_tuser[0]);
                  failures++;
               end
            end
         end
         if (receiver_hold > 0) begin
            hold_left     = receiver_hold;
            receiver_hold = 0;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 9) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_element();
      test_extremes();
      test_equal_values();
      test_rising_run();
      test_falling_run();
      wait_results_drained();
      test_full_store();
      wait_results_drained();
      test_receiver_hold();
      test_random_runs(10);
      wait_results_drained();
      idle_on = 1'b0;
      test_random_runs(6);

      wait_results_drained();
      repeat (200) @(posedge clock);

      $display("covered %0d runs, %0d input beats, %0d result beats checked",
               runs_sent, items_sent, results_seen);
      $display("runs with dropped elements: %0d, long receiver hold: 300 cycles",
               overflow_runs);
      if (failures == 0)
         $display("[suffix_maximum_leader_filter] OK");
      else
         $display("[suffix_maximum_leader_filter] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
sv/slmf_pkg.sv
sv/slmf_ctrl.sv
sv/slmf_dpath.sv
sv/suffix_maximum_leader_filter.sv
sv/slmf_checker.sv
tb/sv/testbench.sv
